// File: design/view_angle_slew_step_core_assert.svh
// Assertion macros shared by the checker of the view angle slew core.
`ifndef VIEW_ANGLE_SLEW_STEP_CORE_ASSERT_SVH
`define VIEW_ANGLE_SLEW_STEP_CORE_ASSERT_SVH

// The consequent must hold whenever the antecedent holds.
`define VASS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VASS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/vass_pkg.sv
`default_nettype none

package vass_pkg;

  // Default number of fraction bits of the angle format.
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  // Fixed field widths of the ports.
  localparam int IN_W   = 26;
  localparam int OUT_W  = 27;
  localparam int STEP_W = 24;

endpackage

`default_nettype wire

// File: design/vass_sqrt.sv
`default_nettype none

// Pipelined integer square root, one root bit resolved per stage.
module vass_sqrt #(
  parameter int SW    = 55,
  parameter int TAG_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [SW-1:0]           radicand,
  input  logic [TAG_W-1:0]        in_tag,
  output logic                    out_valid,
  output logic [(SW+1)/2-1:0]     root,
  output logic [TAG_W-1:0]        out_tag
);

  localparam int RW = (SW + 1) / 2;
  localparam int XW = 2 * RW;

  logic             v      [0:RW-1];
  logic [XW-1:0]    rad    [0:RW-1];
  logic [RW+1:0]    rem    [0:RW-1];
  logic [RW-1:0]    rt     [0:RW-1];
  logic [TAG_W-1:0] tg     [0:RW-1];

  logic             v_next   [0:RW-1];
  logic [XW-1:0]    rad_next [0:RW-1];
  logic [RW+1:0]    rem_next [0:RW-1];
  logic [RW-1:0]    rt_next  [0:RW-1];
  logic [TAG_W-1:0] tg_next  [0:RW-1];

  always_comb begin
    for (int k = 0; k < RW; k++) begin
      logic             pv;
      logic [XW-1:0]    prad;
      logic [RW+1:0]    prem;
      logic [RW-1:0]    prt;
      logic [TAG_W-1:0] ptg;
      logic [RW+2:0]    cur;
      logic [RW+2:0]    trial;
      if (k == 0) begin
        pv   = in_valid;
        prad = XW'(radicand);
        prem = '0;
        prt  = '0;
        ptg  = in_tag;
      end else begin
        pv   = v[k-1];
        prad = rad[k-1];
        prem = rem[k-1];
        prt  = rt[k-1];
        ptg  = tg[k-1];
      end
      // The remainder never exceeds twice the partial root, so its top bit is zero.
      cur   = {prem[RW:0], prad[XW-1 -: 2]};
      trial = (RW+3)'({prt, 2'b01});
      v_next[k]   = pv;
      rad_next[k] = prad << 2;
      tg_next[k]  = ptg;
      if (cur >= trial) begin
        rem_next[k] = (RW+2)'(cur - trial);
        rt_next[k]  = {prt[RW-2:0], 1'b1};
      end else begin
        rem_next[k] = (RW+2)'(cur);
        rt_next[k]  = {prt[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RW; k++) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else begin
        v[k] <= v_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RW; k++) begin
      rad[k] <= rad_next[k];
      rem[k] <= rem_next[k];
      rt[k]  <= rt_next[k];
      tg[k]  <= tg_next[k];
    end
  end

  assign out_valid = v[RW-1];
  assign root      = rt[RW-1];
  assign out_tag   = tg[RW-1];

endmodule

`default_nettype wire

// File: design/vass_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit in QW bits, so the high part of the numerator starts as the
// partial remainder.
module vass_div #(
  parameter int NW    = 52,
  parameter int DVW   = 28,
  parameter int QW    = 24,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NW-1:0]    numer,
  input  logic [DVW-1:0]   denom,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [QW-1:0]    quot,
  output logic [TAG_W-1:0] out_tag
);

  logic [NW+DVW-1:0] numer_hi;
  logic [DVW-1:0]    rem0;

  assign numer_hi = {{DVW{1'b0}}, numer} >> QW;
  assign rem0     = numer_hi[DVW-1:0];

  logic             v    [0:QW-1];
  logic [QW-1:0]    low  [0:QW-1];
  logic [DVW-1:0]   rem  [0:QW-1];
  logic [DVW-1:0]   dv   [0:QW-1];
  logic [QW-1:0]    q    [0:QW-1];
  logic [TAG_W-1:0] tg   [0:QW-1];

  logic             v_next   [0:QW-1];
  logic [QW-1:0]    low_next [0:QW-1];
  logic [DVW-1:0]   rem_next [0:QW-1];
  logic [DVW-1:0]   dv_next  [0:QW-1];
  logic [QW-1:0]    q_next   [0:QW-1];
  logic [TAG_W-1:0] tg_next  [0:QW-1];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      logic             pv;
      logic [QW-1:0]    plow;
      logic [DVW-1:0]   prem;
      logic [DVW-1:0]   pdv;
      logic [QW-1:0]    pq;
      logic [TAG_W-1:0] ptg;
      logic [DVW:0]     cur;
      if (k == 0) begin
        pv   = in_valid;
        plow = numer[QW-1:0];
        prem = rem0;
        pdv  = denom;
        pq   = '0;
        ptg  = in_tag;
      end else begin
        pv   = v[k-1];
        plow = low[k-1];
        prem = rem[k-1];
        pdv  = dv[k-1];
        pq   = q[k-1];
        ptg  = tg[k-1];
      end
      cur          = {prem, plow[QW-1]};
      v_next[k]    = pv;
      low_next[k]  = plow << 1;
      dv_next[k]   = pdv;
      tg_next[k]   = ptg;
      if (cur >= {1'b0, pdv}) begin
        rem_next[k] = DVW'(cur - {1'b0, pdv});
        q_next[k]   = {pq[QW-2:0], 1'b1};
      end else begin
        rem_next[k] = DVW'(cur);
        q_next[k]   = {pq[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else begin
        v[k] <= v_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      low[k] <= low_next[k];
      rem[k] <= rem_next[k];
      dv[k]  <= dv_next[k];
      q[k]   <= q_next[k];
      tg[k]  <= tg_next[k];
    end
  end

  assign out_valid = v[QW-1];
  assign quot      = q[QW-1];
  assign out_tag   = tg[QW-1];

endmodule

`default_nettype wire

// File: design/view_angle_slew_step_core.sv
`default_nettype none

// View angle slew step. Each beat presents the current and target pitch and
// yaw plus a step length, all fixed point degrees with ANGLE_FRAC_BITS
// fraction bits, and yields one beat with the new pitch, new yaw and a
// reached flag. busy is always low: a new beat may be started in every cycle
// and every started beat produces exactly one done pulse, in start order.
// The result ports hold their values only for that one done cycle, so the
// receiver must take them then. The pipeline is made of six front stages
// (capture, two wrap steps, difference, products, sum of squares), the
// square root pipeline (one root bit per stage, where RW = DW is the root
// width), one rounding stage, the divider pipeline (24 quotient bits, one
// per stage) and the output register.
module view_angle_slew_step_core
  import vass_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [IN_W-1:0]   current_pitch,
  input  logic signed [IN_W-1:0]   current_yaw,
  input  logic signed [IN_W-1:0]   target_pitch,
  input  logic signed [IN_W-1:0]   target_yaw,
  input  logic [STEP_W-1:0]        step_length,
  output logic                     done,
  output logic signed [OUT_W-1:0]  new_pitch,
  output logic signed [OUT_W-1:0]  new_yaw,
  output logic                     reached
);

  // One full turn in the angle format, and the widths that follow from it.
  localparam longint FULL_I = 64'sd360 <<< ANGLE_FRAC_BITS;
  localparam int FULL_W = $clog2(FULL_I + 1);
  localparam int DW = ((FULL_W > IN_W) ? FULL_W : IN_W) + 2;   // signed differences
  localparam int AW = DW - 1;                                  // magnitudes
  localparam int SW = 2 * AW + 1;                              // sum of squares
  localparam int RW = (SW + 1) / 2;                            // vector length
  localparam int PW = AW + STEP_W;                             // |d| * step
  localparam int NW = PW + 1;                                  // plus rounding half
  localparam int LATENCY = 32 + RW;

  localparam logic signed [DW-1:0] FULL = DW'(FULL_I);

  typedef struct packed {
    logic signed [DW-1:0] cp;
    logic signed [DW-1:0] cy;
    logic signed [DW-1:0] tp;
    logic signed [DW-1:0] ty;
    logic                 sx;
    logic                 snapx;
    logic                 snapy;
  } side_t;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
    mag = x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

  // The receiver never stalls, so the pipeline always advances.
  assign busy = 1'b0;

  // Stage 0: capture the beat, sign extended to the working width.
  logic                 v0;
  logic signed [DW-1:0] cp0, cy0, tp0, ty0;
  logic [STEP_W-1:0]    st0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    cp0 <= DW'(current_pitch);
    cy0 <= DW'(current_yaw);
    tp0 <= DW'(target_pitch);
    ty0 <= DW'(target_yaw);
    st0 <= step_length;
  end

  // Stage 1: add a full turn to the target yaw if that strictly shortens
  // the yaw difference.
  logic                 v1;
  logic signed [DW-1:0] cp1, cy1, tp1, ty1;
  logic [STEP_W-1:0]    st1;
  logic signed [DW-1:0] e0;

  assign e0 = ty0 - cy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    cp1 <= cp0;
    cy1 <= cy0;
    tp1 <= tp0;
    ty1 <= (mag(e0) > mag(e0 + FULL)) ? ty0 + FULL : ty0;
    st1 <= st0;
  end

  // Stage 2: then subtract a full turn under the same rule. A tie keeps
  // the target where it is.
  logic                 v2;
  logic signed [DW-1:0] cp2, cy2, tp2, ty2;
  logic [STEP_W-1:0]    st2;
  logic signed [DW-1:0] e1;

  assign e1 = ty1 - cy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    cp2 <= cp1;
    cy2 <= cy1;
    tp2 <= tp1;
    ty2 <= (mag(e1) > mag(e1 - FULL)) ? ty1 - FULL : ty1;
    st2 <= st1;
  end

  // Stage 3: difference vector as sign and magnitude.
  logic                 v3;
  logic signed [DW-1:0] cp3, cy3, tp3, ty3;
  logic [STEP_W-1:0]    st3;
  logic [AW-1:0]        ax3, ay3;
  logic                 sx3, sy3;
  logic signed [DW-1:0] dx2, dy2;
  logic [DW-1:0]        mx2, my2;

  assign dx2 = tp2 - cp2;
  assign dy2 = ty2 - cy2;
  assign mx2 = mag(dx2);
  assign my2 = mag(dy2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    cp3 <= cp2;
    cy3 <= cy2;
    tp3 <= tp2;
    ty3 <= ty2;
    st3 <= st2;
    ax3 <= mx2[AW-1:0];
    ay3 <= my2[AW-1:0];
    sx3 <= dx2[DW-1];
    sy3 <= dy2[DW-1];
  end

  // Stage 4: squares for the length, products for the moves, and the
  // snap decisions for each axis.
  logic              v4;
  side_t             sd4;
  logic              sy4;
  logic [2*AW-1:0]   sqx4, sqy4;
  logic [PW-1:0]     prx4, pry4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    sd4.cp    <= cp3;
    sd4.cy    <= cy3;
    sd4.tp    <= tp3;
    sd4.ty    <= ty3;
    sd4.sx    <= sx3;
    sd4.snapx <= ax3 <= AW'(st3);
    sd4.snapy <= ay3 <= AW'(st3);
    sy4       <= sy3;
    sqx4      <= ax3 * ax3;
    sqy4      <= ay3 * ay3;
    prx4      <= ax3 * st3;
    pry4      <= ay3 * st3;
  end

  // Stage 5: sum of squares.
  logic              v5;
  side_t             sd5;
  logic              sy5;
  logic [SW-1:0]     sum5;
  logic [PW-1:0]     prx5, pry5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    sd5  <= sd4;
    sy5  <= sy4;
    sum5 <= SW'(sqx4) + SW'(sqy4);
    prx5 <= prx4;
    pry5 <= pry4;
  end

  // Vector length by the root pipeline; everything else rides along.
  localparam int SQ_TAG_W = $bits(side_t) + 1 + 2 * PW;

  logic                v6;
  logic [RW-1:0]       len6;
  logic [SQ_TAG_W-1:0] sq_tag6;
  side_t               sd6;
  logic                sy6;
  logic [PW-1:0]       prx6, pry6;

  vass_sqrt #(
    .SW    (SW),
    .TAG_W (SQ_TAG_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .radicand  (sum5),
    .in_tag    ({sd5, sy5, prx5, pry5}),
    .out_valid (v6),
    .root      (len6),
    .out_tag   (sq_tag6)
  );

  assign {sd6, sy6, prx6, pry6} = sq_tag6;

  // Numerators with half the length added, so the quotient rounds to
  // nearest.
  logic          v7;
  side_t         sd7;
  logic          sy7;
  logic          lenz7;
  logic [RW-1:0] len7;
  logic [NW-1:0] nx7, ny7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    sd7   <= sd6;
    sy7   <= sy6;
    lenz7 <= len6 == '0;
    len7  <= len6;
    nx7   <= NW'(prx6) + NW'(len6 >> 1);
    ny7   <= NW'(pry6) + NW'(len6 >> 1);
  end

  // Per-axis moves. A zero length gives a meaningless quotient that the
  // final stage ignores.
  localparam int DX_TAG_W = $bits(side_t) + 1;

  logic                vx8, vy8;
  logic [STEP_W-1:0]   qx8, qy8;
  logic [DX_TAG_W-1:0] dx_tag8;
  side_t               sd8;
  logic                lenz8;
  logic                sy8;

  vass_div #(
    .NW    (NW),
    .DVW   (RW),
    .QW    (STEP_W),
    .TAG_W (DX_TAG_W)
  ) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .numer     (nx7),
    .denom     (len7),
    .in_tag    ({sd7, lenz7}),
    .out_valid (vx8),
    .quot      (qx8),
    .out_tag   (dx_tag8)
  );

  vass_div #(
    .NW    (NW),
    .DVW   (RW),
    .QW    (STEP_W),
    .TAG_W (1)
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .numer     (ny7),
    .denom     (len7),
    .in_tag    (sy7),
    .out_valid (vy8),
    .quot      (qy8),
    .out_tag   (sy8)
  );

  assign {sd8, lenz8} = dx_tag8;

  // Final stage: apply the moves, snap each axis that lies within the step,
  // and flag when both axes sit on the wrapped target.
  logic signed [DW-1:0] np8, ny8;

  always_comb begin
    np8 = sd8.cp;
    ny8 = sd8.cy;
    if (!lenz8) begin
      np8 = sd8.sx ? sd8.cp - DW'(qx8) : sd8.cp + DW'(qx8);
      ny8 = sy8    ? sd8.cy - DW'(qy8) : sd8.cy + DW'(qy8);
    end
    if (sd8.snapx) begin
      np8 = sd8.tp;
    end
    if (sd8.snapy) begin
      ny8 = sd8.ty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vx8 && vy8;
    end
    new_pitch <= np8[OUT_W-1:0];
    new_yaw   <= ny8[OUT_W-1:0];
    reached   <= (np8 == sd8.tp) && (ny8 == sd8.ty);
  end

endmodule

`default_nettype wire

// File: design/vass_checker.sv
`default_nettype none

`include "view_angle_slew_step_core_assert.svh"

// Port-level checks of the slew core: fixed latency and reached behavior.
module vass_checker
  import vass_pkg::*;
#(
  parameter int LATENCY = 60
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic signed [IN_W-1:0]  current_pitch,
  input logic signed [IN_W-1:0]  current_yaw,
  input logic signed [IN_W-1:0]  target_pitch,
  input logic signed [IN_W-1:0]  target_yaw,
  input logic                    done,
  input logic signed [OUT_W-1:0] new_pitch,
  input logic                    reached
);

  logic accepted;
  logic same_angles;

  assign accepted    = start && !busy;
  assign same_angles = (current_pitch == target_pitch) && (current_yaw == target_yaw);

  `VASS_ASSERT_IMP(a_done_has_beat, clk, rst, done, $past(accepted && !rst, LATENCY), "done without a beat started at the pipeline latency")
  `VASS_ASSERT_NEXT(a_beat_gives_done, clk, rst, accepted, ##(LATENCY - 1) done, "beat started but no done at the pipeline latency")
  `VASS_ASSERT_IMP(a_zero_diff_reached, clk, rst, done && $past(same_angles, LATENCY), reached, "no move needed but reached is low")
  `VASS_ASSERT_IMP(a_reached_pitch, clk, rst, done && reached, new_pitch == OUT_W'($past(target_pitch, LATENCY)), "reached but pitch is off target")

endmodule

bind view_angle_slew_step_core vass_checker #(.LATENCY(LATENCY)) u_vass_checker (.*);

`default_nettype wire

// File: verif/view_angle_slew_step_checker.sv
`timescale 1ns / 100ps
`default_nettype none

// Watches the command and result sides of the slew core, works out the
// expected beat for each accepted command and compares it with the result.
module view_angle_slew_step_checker
  import vass_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire logic signed [IN_W-1:0]  current_pitch,
  input  wire logic signed [IN_W-1:0]  current_yaw,
  input  wire logic signed [IN_W-1:0]  target_pitch,
  input  wire logic signed [IN_W-1:0]  target_yaw,
  input  wire logic [STEP_W-1:0]       step_length,
  input  wire logic                    done,
  input  wire logic signed [OUT_W-1:0] new_pitch,
  input  wire logic signed [OUT_W-1:0] new_yaw,
  input  wire logic                    reached,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic [OUT_W-1:0] pitch;
    logic [OUT_W-1:0] yaw;
    logic             hit;
  } slew_beat_t;

  slew_beat_t expected_slews[$];

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Per-axis move, rounded to nearest with halves away from zero.
  function automatic longint axis_step(longint d, longint unsigned stp,
                                       longint unsigned len);
    longint unsigned q;
    q = (mag(d) * stp + (len >> 1)) / len;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic slew_beat_t slew_one(longint cp, longint cy, longint tp,
                                          longint ty, longint unsigned stp);
    longint full_turn;
    longint dx;
    longint dy;
    longint np;
    longint ny;
    longint unsigned len;
    slew_beat_t r;
    full_turn = longint'(360) << ANGLE_FRAC_BITS;
    // Shift the target yaw a full turn when that strictly shortens the turn.
    if (mag(ty - cy) > mag(ty + full_turn - cy)) ty = ty + full_turn;
    if (mag(ty - cy) > mag(ty - full_turn - cy)) ty = ty - full_turn;
    dx = tp - cp;
    dy = ty - cy;
    len = floor_sqrt(mag(dx) * mag(dx) + mag(dy) * mag(dy));
    np = cp;
    ny = cy;
    if (len != 0) begin
      np = cp + axis_step(dx, stp, len);
      ny = cy + axis_step(dy, stp, len);
    end
    if (mag(dx) <= stp) np = tp;
    if (mag(dy) <= stp) ny = ty;
    r.pitch = np[OUT_W-1:0];
    r.yaw   = ny[OUT_W-1:0];
    r.hit   = (np == tp) && (ny == ty);
    return r;
  endfunction

  always @(posedge clk) begin
    slew_beat_t want;
    slew_beat_t fresh;
    if (rst) begin
      expected_slews.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (expected_slews.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("%0t: result beat with no command outstanding", $time);
        end else begin
          want = expected_slews.pop_front();
          if (want.pitch !== new_pitch || want.yaw !== new_yaw ||
              want.hit !== reached) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("%0t: mismatch exp p=%0d y=%0d r=%0b got p=%0d y=%0d r=%0b",
                       $time, $signed(want.pitch), $signed(want.yaw), want.hit,
                       new_pitch, new_yaw, reached);
          end
        end
      end
      if (start && !busy) begin
        fresh = slew_one(current_pitch, current_yaw, target_pitch,
                         target_yaw, step_length);
        expected_slews = {expected_slews, fresh};
      end
    end
    pending = expected_slews.size();
  end

endmodule

`default_nettype wire

// File: verif/view_angle_slew_step_core_test.sv
`timescale 1ns / 100ps
`default_nettype none

// Top of the slew core bench. It generates command beats, applies sender
// gaps in three phases and gives the verdict; the checker does all the
// prediction and comparison.
module view_angle_slew_step_core_test;
  import vass_pkg::*;

  localparam int FRAC   = ANGLE_FRAC_BITS_DEF;
  localparam int DEG    = 1 << FRAC;
  localparam int RANGE  = 360 * DEG;
  localparam int HALF   = 180 * DEG;
  // Extra wait at the end of the run, longer than the core takes to answer a command.
  localparam int DRAIN  = 80;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic signed [IN_W-1:0]  current_pitch;
  logic signed [IN_W-1:0]  current_yaw;
  logic signed [IN_W-1:0]  target_pitch;
  logic signed [IN_W-1:0]  target_yaw;
  logic [STEP_W-1:0]       step_length;
  logic                    done;
  logic signed [OUT_W-1:0] new_pitch;
  logic signed [OUT_W-1:0] new_yaw;
  logic                    reached;
  int                      fail_count;
  int                      pending;
  int                      gap_pct;
  int                      early_miss;

  view_angle_slew_step_core u_top (.*);

  view_angle_slew_step_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous fixed ceiling on the whole run.
  initial begin
    #5ms;
    $display("view_angle_slew_step_core verification failed");
    $finish;
  end

  // Puts one command beat on the ports and holds it until the core takes it.
  // Each cycle before the beat idles with a chance of gap_pct in a hundred.
  // busy only changes on a rising edge, so reading it at the falling edge
  // tells whether the next rising edge accepts the beat. start is left high
  // so that back-to-back beats never need a second assignment in one step.
  task automatic send_slew(int cp, int cy, int tp, int ty, int stp);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    current_pitch <= cp[IN_W-1:0];
    current_yaw   <= cy[IN_W-1:0];
    target_pitch  <= tp[IN_W-1:0];
    target_yaw    <= ty[IN_W-1:0];
    step_length   <= stp[STEP_W-1:0];
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic int in_range_angle();
    return int'($urandom_range(0, 2 * RANGE / 2 * 2 / 2 + RANGE)) - RANGE;
  endfunction

  // Random beat. Most beats stay in the specified ranges; some use every
  // raw bit pattern, some sit near the snap threshold or the half turn.
  task automatic random_slew();
    int cp;
    int cy;
    int tp;
    int ty;
    int stp;
    int kind;
    kind = $urandom_range(99);
    cp = in_range_angle();
    cy = in_range_angle();
    tp = in_range_angle();
    ty = in_range_angle();
    stp = $urandom_range(0, 180 * DEG);
    if (kind < 15) begin
      cp = int'($urandom);
      cy = int'($urandom);
      tp = int'($urandom);
      ty = int'($urandom);
      stp = int'($urandom);
    end else if (kind < 40) begin
      // Close to the target, so that one or both axes may snap.
      tp = cp + int'($urandom_range(0, 2 * DEG)) - DEG;
      ty = cy + int'($urandom_range(0, 2 * DEG)) - DEG;
      stp = $urandom_range(0, 2 * DEG);
    end else if (kind < 50) begin
      // Yaw difference around half a turn, including exact ties.
      ty = cy + (($urandom_range(1)) ? HALF : -HALF) + int'($urandom_range(0, 4)) - 2;
    end else if (kind < 55) begin
      stp = 0;
    end else if (kind < 60) begin
      stp = $urandom_range(0, 64);
    end
    send_slew(cp, cy, tp, ty, stp);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    current_pitch = '0;
    current_yaw = '0;
    target_pitch = '0;
    target_yaw = '0;
    step_length = '0;
    gap_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats: zero difference, zero step, field extremes, snaps,
    // wrap in both directions and the half-turn tie.
    send_slew(0, 0, 0, 0, 0);
    send_slew(5 * DEG, -7 * DEG, 5 * DEG, -7 * DEG, 3 * DEG);
    send_slew(0, 0, 10 * DEG, 10 * DEG, 0);
    send_slew(DEG, DEG, DEG, 4 * DEG, 0);
    send_slew(-RANGE, -RANGE, RANGE, RANGE, 180 * DEG);
    send_slew(RANGE, RANGE, -RANGE, -RANGE, 1);
    send_slew(0, 170 * DEG, 0, -170 * DEG, DEG);
    send_slew(0, -170 * DEG, 0, 170 * DEG, DEG);
    send_slew(0, 0, 0, HALF, DEG);
    send_slew(0, 0, 0, -HALF, DEG);
    send_slew(0, 0, 3 * DEG, 4 * DEG, 5 * DEG);
    send_slew(0, 0, 3 * DEG, 4 * DEG, 2 * DEG);
    send_slew(0, 0, 30 * DEG, DEG / 2, DEG);
    send_slew(-33554432, -33554432, 33554431, 33554431, 16777215);
    send_slew(33554431, 33554431, -33554432, -33554432, 16777215);
    send_slew(-33554432, 33554431, 33554431, -33554432, 12345);
    send_slew(0, 0, 1, 1, 1);
    send_slew(0, 0, -1, 0, 0);
    send_slew(21845, 43690, 43690, 21845, 11184810);
    send_slew(0, 0, 45 * DEG, -45 * DEG, 16777215);

    // Hold off until every directed result has come back.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    gap_pct = 32;
    repeat (200) random_slew();
    gap_pct = 49;
    repeat (200) random_slew();
    gap_pct = 0;
    repeat (200) random_slew();

    start <= 1'b0;
    early_miss = 0;
    while (pending != 0 && early_miss < 10000) begin
      @(posedge clk);
      early_miss++;
    end
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("view_angle_slew_step_core verification clean");
    end else begin
      $display("view_angle_slew_step_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
